// ===== rtl/tpkf_pkg.sv =====
// Package for the TCP port and payload-prefix frame filter: word types and header constants.
`default_nettype none

package tpkf_pkg;

  // One frame byte as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // One verdict word, given at the end of each frame.
  typedef struct packed {
    logic        drop;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dst_tcp_port;
  } out_word_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_WATCH_PORT     = 2'd0,
    CFG_KEYWORD_BYTES  = 2'd1,
    CFG_KEYWORD_LENGTH = 2'd2
  } cfg_reg_t;

  // Register reset values.
  localparam logic [15:0] WATCH_PORT_RESET     = 16'd8080;
  localparam logic [63:0] KEYWORD_BYTES_RESET  = 64'd9325100978226234;  // "!!!CMD:"
  localparam logic [2:0]  KEYWORD_LENGTH_RESET = 3'd7;

  // Frame layout: 14-byte Ethernet header, fixed 20-byte IPv4 header.
  localparam logic [15:0] ETH_LEN     = 16'd14;
  localparam logic [15:0] IP_LEN      = 16'd20;
  localparam logic [15:0] TCP_START   = 16'd34;
  localparam logic [15:0] TCP_MIN_END = 16'd54;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;

  // Byte positions of captured header fields.
  localparam logic [15:0] POS_TOT_LEN_HI  = 16'd16;
  localparam logic [15:0] POS_TOT_LEN_LO  = 16'd17;
  localparam logic [15:0] POS_PROTOCOL    = 16'd23;
  localparam logic [15:0] POS_SRC_IP      = 16'd26;
  localparam logic [15:0] POS_DST_IP      = 16'd30;
  localparam logic [15:0] POS_SRC_PORT_HI = 16'd34;
  localparam logic [15:0] POS_SRC_PORT_LO = 16'd35;
  localparam logic [15:0] POS_DST_PORT_HI = 16'd36;
  localparam logic [15:0] POS_DST_PORT_LO = 16'd37;
  localparam logic [15:0] POS_DATA_OFFSET = 16'd46;

  // One match lane per possible TCP data offset value.
  localparam int unsigned DOFF_LANES = 16;

endpackage

`default_nettype wire

// ===== rtl/tcp_port_keyword_packet_filter_top.sv =====
// Top level of the TCP port and payload-prefix frame filter.
// A verdict word is registered and becomes valid in the cycle after the frame's last byte is accepted.
// Throughput: one byte per cycle; the input stalls only when a verdict still waits.
// Header capture and all 16 prefix lanes are combinational on each accepted byte.
// Reset: synchronous, active low; clears frame state and restores default config values.
`default_nettype none

module tcp_port_keyword_packet_filter_top #(
  parameter int unsigned MAX_KEYWORD_BYTES = 7
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // input byte stream
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  tpkf_pkg::in_word_t                   in_data,
  // verdict stream
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output tpkf_pkg::out_word_t                  out_data,
  // config write port
  input  wire                                  cfg_we,
  input  wire [1:0]                            cfg_addr,
  input  wire [((8*MAX_KEYWORD_BYTES > 16) ? 8*MAX_KEYWORD_BYTES : 16)-1:0] cfg_wdata
);
  import tpkf_pkg::*;

  localparam int unsigned KW_W  = 8 * MAX_KEYWORD_BYTES;
  localparam logic [3:0]  KW_MAX = 4'(MAX_KEYWORD_BYTES);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [15:0]     watch_port_r;
  logic [KW_W-1:0] keyword_r;
  logic [2:0]      keyword_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watch_port_r  <= WATCH_PORT_RESET;
      keyword_r     <= KW_W'(KEYWORD_BYTES_RESET);
      keyword_len_r <= KEYWORD_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_WATCH_PORT:     watch_port_r  <= cfg_wdata[15:0];
        CFG_KEYWORD_BYTES:  keyword_r     <= cfg_wdata[KW_W-1:0];
        CFG_KEYWORD_LENGTH: keyword_len_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // effective keyword length, clipped to the keyword register size
  logic [3:0] key_len;
  assign key_len = ({1'b0, keyword_len_r} > KW_MAX) ? KW_MAX : {1'b0, keyword_len_r};

  // keyword split into bytes, first payload byte at index 0; unused slots are zero
  logic [7:0] key_arr [8];
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      key_arr[j] = 8'h00;
    end
    for (int j = 0; j < int'(MAX_KEYWORD_BYTES); j++) begin
      key_arr[j] = keyword_r[8*(int'(MAX_KEYWORD_BYTES)-1-j) +: 8];
    end
  end

  // ---------------------------------------------------------------------------
  // Per-frame state
  // ---------------------------------------------------------------------------
  logic [15:0] byte_cnt_r,  byte_cnt_nxt;
  logic [7:0]  protocol_r,  protocol_nxt;
  logic [15:0] tot_len_r,   tot_len_nxt;
  logic [31:0] src_ip_r,    src_ip_nxt;
  logic [31:0] dst_ip_r,    dst_ip_nxt;
  logic [15:0] tcp_sport_r, tcp_sport_nxt;
  logic [15:0] dst_port_r,  dst_port_nxt;
  logic [3:0]  doff_r,      doff_nxt;
  logic [DOFF_LANES-1:0] match_r, match_nxt;

  // values after this byte, before the end-of-frame clear
  logic [15:0] cnt_upd;
  logic [7:0]  proto_upd;
  logic [15:0] tlen_upd;
  logic [31:0] sip_upd;
  logic [31:0] dip_upd;
  logic [15:0] sport_upd;
  logic [15:0] dport_upd;
  logic [3:0]  doff_upd;
  logic [DOFF_LANES-1:0] match_upd;

  logic        in_acc;
  logic [15:0] pos;
  logic [7:0]  b;

  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign pos      = byte_cnt_r;
  assign b        = in_data.data_byte;

  // header field capture
  always_comb begin
    cnt_upd   = (byte_cnt_r != 16'hFFFF) ? byte_cnt_r + 16'd1 : byte_cnt_r;
    proto_upd = protocol_r;
    tlen_upd  = tot_len_r;
    sip_upd   = src_ip_r;
    dip_upd   = dst_ip_r;
    sport_upd = tcp_sport_r;
    dport_upd = dst_port_r;
    doff_upd  = doff_r;
    if (pos == POS_TOT_LEN_HI)  tlen_upd[15:8]  = b;
    if (pos == POS_TOT_LEN_LO)  tlen_upd[7:0]   = b;
    if (pos == POS_PROTOCOL)    proto_upd       = b;
    if (pos == POS_SRC_IP)          sip_upd[31:24] = b;
    if (pos == POS_SRC_IP + 16'd1)  sip_upd[23:16] = b;
    if (pos == POS_SRC_IP + 16'd2)  sip_upd[15:8]  = b;
    if (pos == POS_SRC_IP + 16'd3)  sip_upd[7:0]   = b;
    if (pos == POS_DST_IP)          dip_upd[31:24] = b;
    if (pos == POS_DST_IP + 16'd1)  dip_upd[23:16] = b;
    if (pos == POS_DST_IP + 16'd2)  dip_upd[15:8]  = b;
    if (pos == POS_DST_IP + 16'd3)  dip_upd[7:0]   = b;
    if (pos == POS_SRC_PORT_HI) sport_upd[15:8] = b;
    if (pos == POS_SRC_PORT_LO) sport_upd[7:0]  = b;
    if (pos == POS_DST_PORT_HI) dport_upd[15:8] = b;
    if (pos == POS_DST_PORT_LO) dport_upd[7:0]  = b;
    if (pos == POS_DATA_OFFSET) doff_upd        = b[7:4];
  end

  // prefix lanes: lane d checks the payload that would start at TCP start + 4*d
  always_comb begin
    logic [15:0] start;
    logic [15:0] off;
    match_upd = match_r;
    for (int d = 0; d < int'(DOFF_LANES); d++) begin
      start = TCP_START + 16'(4 * d);
      off   = pos - start;
      if ((pos >= start) && (off < {12'd0, key_len})) begin
        if (b != key_arr[off[2:0]]) match_upd[d] = 1'b0;
      end
    end
  end

  // end-of-frame clear
  always_comb begin
    if (in_data.last_byte) begin
      byte_cnt_nxt  = '0;
      protocol_nxt  = '0;
      tot_len_nxt   = '0;
      src_ip_nxt    = '0;
      dst_ip_nxt    = '0;
      tcp_sport_nxt = '0;
      dst_port_nxt  = '0;
      doff_nxt      = '0;
      match_nxt     = '1;
    end else begin
      byte_cnt_nxt  = cnt_upd;
      protocol_nxt  = proto_upd;
      tot_len_nxt   = tlen_upd;
      src_ip_nxt    = sip_upd;
      dst_ip_nxt    = dip_upd;
      tcp_sport_nxt = sport_upd;
      dst_port_nxt  = dport_upd;
      doff_nxt      = doff_upd;
      match_nxt     = match_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r  <= '0;
      protocol_r  <= '0;
      tot_len_r   <= '0;
      src_ip_r    <= '0;
      dst_ip_r    <= '0;
      tcp_sport_r <= '0;
      dst_port_r  <= '0;
      doff_r      <= '0;
      match_r     <= '1;
    end else if (in_acc) begin
      byte_cnt_r  <= byte_cnt_nxt;
      protocol_r  <= protocol_nxt;
      tot_len_r   <= tot_len_nxt;
      src_ip_r    <= src_ip_nxt;
      dst_ip_r    <= dst_ip_nxt;
      tcp_sport_r <= tcp_sport_nxt;
      dst_port_r  <= dst_port_nxt;
      doff_r      <= doff_nxt;
      match_r     <= match_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict, from the state as it stands after the last byte
  // ---------------------------------------------------------------------------
  logic      drop_now;
  logic      len_ok;
  logic      pay_ok;
  logic      bound_ok;
  out_word_t verdict;

  assign len_ok   = cnt_upd >= TCP_MIN_END;
  // payload = tot_len - 20 - 4*doff must reach the keyword length
  assign pay_ok   = {2'b00, tlen_upd} >=
                    (18'(IP_LEN) + {12'd0, doff_upd, 2'b00} + {14'd0, key_len});
  assign bound_ok = (17'(ETH_LEN) + {1'b0, tlen_upd}) <= {1'b0, cnt_upd};
  assign drop_now = len_ok && (proto_upd == PROTO_TCP) && (dport_upd == watch_port_r)
                    && pay_ok && bound_ok && match_upd[doff_upd];

  always_comb begin
    verdict = '0;
    if (drop_now) begin
      verdict.drop         = 1'b1;
      verdict.source_ip    = sip_upd;
      verdict.dest_ip      = dip_upd;
      verdict.source_port  = sport_upd;
      verdict.dst_tcp_port = dport_upd;
    end
  end

  // output register; the input side keeps flowing while it is free or draining
  logic      out_valid_r;
  out_word_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_data.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.last_byte) begin
      out_data_r <= verdict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.last_byte |=> out_valid_r)
    else $error("no verdict after frame end");

  a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.last_byte |=> byte_cnt_r == 16'd0 && match_r == '1)
    else $error("frame state not cleared at frame end");

  a_pass_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.drop |-> out_data_r.source_ip == 32'd0 &&
      out_data_r.dest_ip == 32'd0 && out_data_r.source_port == 16'd0 &&
      out_data_r.dst_tcp_port == 16'd0)
    else $error("passed frame carries nonzero fields");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r && !out_ready)
    else $error("input stalled with free output slot");

endmodule

`default_nettype wire
